// ===== rtl/motor_axis_supervisor_top_macros.svh =====
// Assertion macros shared by the motor axis supervisor RTL.
// Expects signals named clk and rst_n in the scope that uses them.
`ifndef MOTOR_AXIS_SUPERVISOR_TOP_MACROS_SVH
`define MOTOR_AXIS_SUPERVISOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MAS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mas_pkg.sv =====
// Types and constants of the motor axis supervisor.
// No dependencies; used by the interfaces and every module of the block.
package mas_pkg;

    localparam int CUR_PORT_W = 16;
    localparam int GOOD_W     = 8;
    localparam int LIMIT_W    = 15;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int AXIS_W     = 3;
    localparam int FAULT_W    = 3;
    localparam int CMODE_W    = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_LIMIT    = 2'd2;

    localparam logic [GOOD_W-1:0]  GOOD_SAMPLES_RST = 8'd16;
    localparam logic [LIMIT_W-1:0] LIMIT_OFF        = 15'h7FFF;

    // Tick kinds.
    localparam logic TICK_SLOW = 1'b0;
    localparam logic TICK_FAST = 1'b1;

    // Axis state codes as seen on the result beat.
    localparam logic [AXIS_W-1:0] AXIS_IDLE   = 3'd0;
    localparam logic [AXIS_W-1:0] AXIS_CHECK  = 3'd1;
    localparam logic [AXIS_W-1:0] AXIS_ALIGN  = 3'd2;
    localparam logic [AXIS_W-1:0] AXIS_CLOSED = 3'd3;
    localparam logic [AXIS_W-1:0] AXIS_FAULT  = 3'd4;

    // Fault codes.
    localparam logic [FAULT_W-1:0] FAULT_NONE    = 3'd0;
    localparam logic [FAULT_W-1:0] FAULT_ENCODER = 3'd1;
    localparam logic [FAULT_W-1:0] FAULT_CURRENT = 3'd2;
    localparam logic [FAULT_W-1:0] FAULT_TIMEOUT = 3'd3;

    // Control modes.
    localparam logic [CMODE_W-1:0] CMODE_OFF    = 2'd0;
    localparam logic [CMODE_W-1:0] CMODE_VF     = 2'd1;
    localparam logic [CMODE_W-1:0] CMODE_IF     = 2'd2;
    localparam logic [CMODE_W-1:0] CMODE_CLOSED = 2'd3;

    typedef struct packed {
        logic loop_ready;
        logic pwm_ok;
        logic amps_ok;
        logic enc_good;
    } check_flags_t;

    typedef struct packed {
        logic                   mode;
        logic                   enable;
        logic [CMODE_W-1:0]     drive_mode;
        logic                   encoder_safe;
        logic [CUR_PORT_W-1:0]  current_u;
        logic [CUR_PORT_W-1:0]  current_v;
        logic [CUR_PORT_W-1:0]  current_w;
        logic [CUR_PORT_W-1:0]  current_sum;
        logic                   pwm_safe;
        logic                   align_done;
        logic [FAULT_W-1:0]     motor_fault;
    } item_t;

    typedef struct packed {
        logic [AXIS_W-1:0]  axis_state;
        logic [FAULT_W-1:0] first_fault;
        logic               enter_safe;
        logic               reset_control;
        logic               reset_open_loop;
        logic               reset_encoder;
        logic               run_align;
        logic               run_control;
        check_flags_t       flags;
    } result_t;

    typedef struct packed {
        logic [GOOD_W-1:0]  good_samples_needed;
        logic [LIMIT_W-1:0] phase_current_limit;
        logic [LIMIT_W-1:0] current_sum_limit;
    } cfg_t;

endpackage

// ===== rtl/mas_tick_if.sv =====
// Valid/ready channel that carries one tick beat into the supervisor.
// Depends on mas_pkg for field widths.
interface mas_tick_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic                               enable;
    logic [mas_pkg::CMODE_W-1:0]        drive_mode;
    logic                               encoder_safe;
    logic signed [mas_pkg::CUR_PORT_W-1:0] current_u;
    logic signed [mas_pkg::CUR_PORT_W-1:0] current_v;
    logic signed [mas_pkg::CUR_PORT_W-1:0] current_w;
    logic signed [mas_pkg::CUR_PORT_W-1:0] current_sum;
    logic                               pwm_safe;
    logic                               align_done;
    logic [mas_pkg::FAULT_W-1:0]        motor_fault;

    modport source (
        output valid, mode, enable, drive_mode, encoder_safe, current_u, current_v,
               current_w, current_sum, pwm_safe, align_done, motor_fault,
        input  ready
    );
    modport sink (
        input  valid, mode, enable, drive_mode, encoder_safe, current_u, current_v,
               current_w, current_sum, pwm_safe, align_done, motor_fault,
        output ready
    );
endinterface

// ===== rtl/mas_status_if.sv =====
// Valid/ready channel that carries one status beat out of the supervisor.
// Depends on mas_pkg for field widths.
interface mas_status_if;
    logic                        valid;
    logic                        ready;
    logic [mas_pkg::AXIS_W-1:0]  axis_state;
    logic [mas_pkg::FAULT_W-1:0] first_fault;
    logic                        enter_safe;
    logic                        reset_control;
    logic                        reset_open_loop;
    logic                        reset_encoder;
    logic                        run_align;
    logic                        run_control;
    logic                        enc_good;
    logic                        amps_ok;
    logic                        pwm_ok;
    logic                        loop_ready;

    modport source (
        output valid, axis_state, first_fault, enter_safe, reset_control, reset_open_loop,
               reset_encoder, run_align, run_control, enc_good, amps_ok, pwm_ok,
               loop_ready,
        input  ready
    );
    modport sink (
        input  valid, axis_state, first_fault, enter_safe, reset_control, reset_open_loop,
               reset_encoder, run_align, run_control, enc_good, amps_ok, pwm_ok,
               loop_ready,
        output ready
    );
endinterface

// ===== rtl/motor_axis_supervisor_top.sv =====
// Top level of the motor axis supervisor: tick register, checks, state machine
// and status register. Depends on mas_pkg, mas_tick_if, mas_status_if, mas_checks,
// mas_fsm and motor_axis_supervisor_top_macros.svh.
//
//   Channel   Kind        Direction  Beat
//   tick      valid/ready in         one slow or fast tick with its samples
//   status    valid/ready out        axis state, requests and check flags
//   cfg_*     write only  in         one register write per enabled cycle
//
// Each accepted tick waits in the tick register, then passes through the check
// and state logic into the status register. One tick is accepted every cycle
// while status beats are not stalled; the state update of one tick is seen by the
// next, since the state registers load in the same edge as the status register.
// A stalled status beat holds its register; the tick register then fills and
// tick.ready drops until the status beat is taken.
// Reset clears the axis to idle, no fault, a zero sample count and zero flags,
// and loads the configuration defaults (16 good samples, both windows off).
`include "motor_axis_supervisor_top_macros.svh"

module motor_axis_supervisor_top #(
    parameter int CURRENT_WIDTH      = 16,
    parameter int SAMPLE_COUNT_WIDTH = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mas_tick_if.sink                         tick,
    mas_status_if.source                     status,
    input  logic                             cfg_we,
    input  logic [mas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mas_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers. Writes to an index past the list are dropped.
    mas_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.good_samples_needed <= mas_pkg::GOOD_SAMPLES_RST;
            cfg_reg.phase_current_limit <= mas_pkg::LIMIT_OFF;
            cfg_reg.current_sum_limit   <= mas_pkg::LIMIT_OFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mas_pkg::CFG_GOOD_SAMPLES:
                    cfg_reg.good_samples_needed <= cfg_data[mas_pkg::GOOD_W-1:0];
                mas_pkg::CFG_PHASE_LIMIT:
                    cfg_reg.phase_current_limit <= cfg_data[mas_pkg::LIMIT_W-1:0];
                mas_pkg::CFG_SUM_LIMIT:
                    cfg_reg.current_sum_limit   <= cfg_data[mas_pkg::LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Handshake control. The tick register drains into the status register
    // whenever the status register is empty or its beat is taken this cycle.
    logic             s1_valid_reg, s1_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic             advance;
    logic             tick_take;
    mas_pkg::item_t   tick_item;
    mas_pkg::item_t   s1_item_reg;
    mas_pkg::result_t res_reg;
    mas_pkg::result_t fsm_result;

    logic [SAMPLE_COUNT_WIDTH-1:0] count;
    logic [SAMPLE_COUNT_WIDTH-1:0] chk_count;
    mas_pkg::check_flags_t         chk_flags;

    assign advance    = s1_valid_reg && (!out_valid_reg || status.ready);
    assign tick.ready = !s1_valid_reg || advance;
    assign tick_take  = tick.valid && tick.ready;

    always_comb
    begin
        tick_item.mode         = tick.mode;
        tick_item.enable       = tick.enable;
        tick_item.drive_mode   = tick.drive_mode;
        tick_item.encoder_safe = tick.encoder_safe;
        tick_item.current_u    = tick.current_u;
        tick_item.current_v    = tick.current_v;
        tick_item.current_w    = tick.current_w;
        tick_item.current_sum  = tick.current_sum;
        tick_item.pwm_safe     = tick.pwm_safe;
        tick_item.align_done   = tick.align_done;
        tick_item.motor_fault  = tick.motor_fault;

        if (tick_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (status.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid bits guard them.
    always_ff @(posedge clk)
    begin
        if (tick_take)
            s1_item_reg <= tick_item;
        if (advance)
            res_reg <= fsm_result;
    end

    mas_checks #(
        .CURRENT_WIDTH      (CURRENT_WIDTH),
        .SAMPLE_COUNT_WIDTH (SAMPLE_COUNT_WIDTH)
    ) u_checks (
        .item       (s1_item_reg),
        .cfg        (cfg_reg),
        .count      (count),
        .count_next (chk_count),
        .flags      (chk_flags)
    );

    mas_fsm #(
        .SAMPLE_COUNT_WIDTH (SAMPLE_COUNT_WIDTH)
    ) u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (s1_item_reg),
        .chk_count (chk_count),
        .chk_flags (chk_flags),
        .count     (count),
        .result    (fsm_result)
    );

    assign status.valid           = out_valid_reg;
    assign status.axis_state      = res_reg.axis_state;
    assign status.first_fault     = res_reg.first_fault;
    assign status.enter_safe      = res_reg.enter_safe;
    assign status.reset_control   = res_reg.reset_control;
    assign status.reset_open_loop = res_reg.reset_open_loop;
    assign status.reset_encoder   = res_reg.reset_encoder;
    assign status.run_align       = res_reg.run_align;
    assign status.run_control     = res_reg.run_control;
    assign status.enc_good        = res_reg.flags.enc_good;
    assign status.amps_ok         = res_reg.flags.amps_ok;
    assign status.pwm_ok          = res_reg.flags.pwm_ok;
    assign status.loop_ready      = res_reg.flags.loop_ready;

    // A latched fault only ever coexists with the fault state.
    `MAS_ASSERT_SAME(a_fault_state, status.valid && (status.first_fault != mas_pkg::FAULT_NONE), status.axis_state == mas_pkg::AXIS_FAULT, "fault latched outside fault state")

    // The readiness flag is the conjunction of the three checks.
    `MAS_ASSERT_SAME(a_ready_flags, status.valid && status.loop_ready, status.enc_good && status.amps_ok && status.pwm_ok, "ready without all checks")

    // A tick leaving the tick register always shows up as a status beat.
    `MAS_ASSERT_NEXT(a_advance_out, advance, status.valid, "advanced tick produced no status beat")

endmodule

// ===== rtl/mas_checks.sv =====
// Slow-tick checks: encoder good-sample counter step and current window checks.
// Purely combinational; depends on mas_pkg.
module mas_checks #(
    parameter int CURRENT_WIDTH      = 16,
    parameter int SAMPLE_COUNT_WIDTH = 8
) (
    input  mas_pkg::item_t                item,
    input  mas_pkg::cfg_t                 cfg,
    input  logic [SAMPLE_COUNT_WIDTH-1:0] count,
    output logic [SAMPLE_COUNT_WIDTH-1:0] count_next,
    output mas_pkg::check_flags_t         flags
);

    localparam int CMP_W = (SAMPLE_COUNT_WIDTH > mas_pkg::GOOD_W) ?
                           SAMPLE_COUNT_WIDTH : mas_pkg::GOOD_W;
    localparam int WIN_W = mas_pkg::LIMIT_W + 2;

    // A limit at full scale switches the window off.
    function automatic logic in_window(input logic [CURRENT_WIDTH-1:0] raw,
                                       input logic [mas_pkg::LIMIT_W-1:0] limit);
        logic signed [WIN_W-1:0] x;
        logic signed [WIN_W-1:0] l;
        x = WIN_W'($signed(raw));
        l = $signed({2'b00, limit});
        return (limit == mas_pkg::LIMIT_OFF) || ((x >= -l) && (x <= l));
    endfunction

    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] needed_ext;
    logic             enc_ok;
    logic             cur_ok;

    always_comb
    begin
        count_ext  = CMP_W'(count);
        needed_ext = CMP_W'(cfg.good_samples_needed);
        if (item.encoder_safe)
        begin
            if ((count_ext < needed_ext) && (count != '1))
                count_next = count + SAMPLE_COUNT_WIDTH'(1);
            else
                count_next = count;
        end
        else
        begin
            count_next = '0;
        end
        enc_ok = CMP_W'(count_next) >= needed_ext;
        cur_ok = in_window(item.current_u[CURRENT_WIDTH-1:0], cfg.phase_current_limit) &&
                 in_window(item.current_v[CURRENT_WIDTH-1:0], cfg.phase_current_limit) &&
                 in_window(item.current_w[CURRENT_WIDTH-1:0], cfg.phase_current_limit) &&
                 in_window(item.current_sum[CURRENT_WIDTH-1:0], cfg.current_sum_limit);
        flags.enc_good   = enc_ok;
        flags.amps_ok    = cur_ok;
        flags.pwm_ok     = item.pwm_safe;
        flags.loop_ready = enc_ok && cur_ok && item.pwm_safe;
    end

endmodule

// ===== rtl/mas_fsm.sv =====
// Axis state machine with the latched fault, sample count and check flags.
// Depends on mas_pkg; takes the check results from mas_checks.
module mas_fsm #(
    parameter int SAMPLE_COUNT_WIDTH = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  mas_pkg::item_t                item,
    input  logic [SAMPLE_COUNT_WIDTH-1:0] chk_count,
    input  mas_pkg::check_flags_t         chk_flags,
    output logic [SAMPLE_COUNT_WIDTH-1:0] count,
    output mas_pkg::result_t              result
);

    typedef enum logic [mas_pkg::AXIS_W-1:0] {
        ST_IDLE   = mas_pkg::AXIS_IDLE,
        ST_CHECK  = mas_pkg::AXIS_CHECK,
        ST_ALIGN  = mas_pkg::AXIS_ALIGN,
        ST_CLOSED = mas_pkg::AXIS_CLOSED,
        ST_FAULT  = mas_pkg::AXIS_FAULT
    } axis_t;

    axis_t                         mode_reg, mode_next;
    logic [mas_pkg::FAULT_W-1:0]   fault_reg, fault_next;
    logic [SAMPLE_COUNT_WIDTH-1:0] count_reg, count_next;
    mas_pkg::check_flags_t         flags_reg, flags_next;

    logic                          open_loop;
    logic                          gf_en;
    logic [mas_pkg::FAULT_W-1:0]   gf_code;
    logic                          safe, rst_ctl, rst_ol, rst_enc, run_al, run_ctl;

    always_comb
    begin
        mode_next  = mode_reg;
        fault_next = fault_reg;
        count_next = count_reg;
        flags_next = flags_reg;
        safe       = 1'b0;
        rst_ctl    = 1'b0;
        rst_ol     = 1'b0;
        rst_enc    = 1'b0;
        run_al     = 1'b0;
        run_ctl    = 1'b0;
        gf_en      = 1'b0;
        gf_code    = mas_pkg::FAULT_NONE;
        open_loop  = (item.drive_mode == mas_pkg::CMODE_VF) ||
                     (item.drive_mode == mas_pkg::CMODE_IF);

        if (item.mode == mas_pkg::TICK_SLOW)
        begin
            count_next = chk_count;
            flags_next = chk_flags;
            if (!item.enable)
            begin
                mode_next  = ST_IDLE;
                fault_next = mas_pkg::FAULT_NONE;
                count_next = '0;
                safe       = 1'b1;
                rst_ctl    = 1'b1;
            end
            else
            begin
                unique case (mode_reg)
                    ST_IDLE:
                    begin
                        safe       = 1'b1;
                        rst_ctl    = 1'b1;
                        rst_enc    = 1'b1;
                        count_next = '0;
                        mode_next  = ST_CHECK;
                    end
                    ST_CHECK:
                    begin
                        if (item.drive_mode == mas_pkg::CMODE_OFF)
                        begin
                            safe    = 1'b1;
                            rst_ctl = 1'b1;
                        end
                        else if (open_loop && chk_flags.amps_ok && chk_flags.pwm_ok)
                        begin
                            rst_ctl   = 1'b1;
                            rst_ol    = 1'b1;
                            mode_next = ST_CLOSED;
                        end
                        else if (chk_flags.loop_ready)
                        begin
                            rst_ctl   = 1'b1;
                            rst_ol    = 1'b1;
                            mode_next = ST_ALIGN;
                        end
                    end
                    ST_ALIGN:
                    begin
                        if (!chk_flags.enc_good)
                        begin
                            gf_en   = 1'b1;
                            gf_code = mas_pkg::FAULT_ENCODER;
                        end
                        else if (!chk_flags.amps_ok)
                        begin
                            gf_en   = 1'b1;
                            gf_code = mas_pkg::FAULT_CURRENT;
                        end
                    end
                    ST_CLOSED:
                    begin
                        if (!open_loop && !chk_flags.enc_good)
                        begin
                            gf_en   = 1'b1;
                            gf_code = mas_pkg::FAULT_ENCODER;
                        end
                        else if (!chk_flags.amps_ok)
                        begin
                            gf_en   = 1'b1;
                            gf_code = mas_pkg::FAULT_CURRENT;
                        end
                    end
                    default:
                    begin
                        safe = 1'b1;
                    end
                endcase
            end
        end
        else if (item.enable)
        begin
            unique case (mode_reg)
                ST_ALIGN:
                begin
                    run_al = 1'b1;
                    if (item.align_done)
                    begin
                        if (item.motor_fault != mas_pkg::FAULT_NONE)
                        begin
                            gf_en   = 1'b1;
                            gf_code = item.motor_fault;
                        end
                        else
                        begin
                            mode_next = ST_CLOSED;
                        end
                    end
                end
                ST_CLOSED:
                begin
                    run_ctl = 1'b1;
                    // An open-loop timeout only drops the power stage to safe.
                    if (item.motor_fault == mas_pkg::FAULT_TIMEOUT)
                    begin
                        safe = 1'b1;
                    end
                    else if (item.motor_fault != mas_pkg::FAULT_NONE)
                    begin
                        gf_en   = 1'b1;
                        gf_code = item.motor_fault;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Only the first fault is kept.
        if (gf_en)
        begin
            if (fault_reg == mas_pkg::FAULT_NONE)
                fault_next = gf_code;
            mode_next = ST_FAULT;
            safe      = 1'b1;
        end

        result.axis_state      = mode_next;
        result.first_fault     = fault_next;
        result.enter_safe      = safe;
        result.reset_control   = rst_ctl;
        result.reset_open_loop = rst_ol;
        result.reset_encoder   = rst_enc;
        result.run_align       = run_al;
        result.run_control     = run_ctl;
        result.flags           = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ST_IDLE;
            fault_reg <= mas_pkg::FAULT_NONE;
            count_reg <= '0;
            flags_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            fault_reg <= fault_next;
            count_reg <= count_next;
            flags_reg <= flags_next;
        end
    end

    assign count = count_reg;

endmodule
